// File: rtl/underwater_vehicle_velocity_step_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the velocity step block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UNDERWATER_VEHICLE_VELOCITY_STEP_ASSERT_SVH
`define UNDERWATER_VEHICLE_VELOCITY_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define UVVS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define UVVS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UVVS_ASSERT_SAME(name, ante, cons, msg)
`define UVVS_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

// File: rtl/uvvs_pkg.sv
// ----------------------------------------------------------------------------
// uvvs_pkg
// Shared types, constants and helpers of the velocity step block.
// ----------------------------------------------------------------------------
package uvvs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FWD_BITS  = 14;
  localparam int DT_BITS   = 16;

  localparam logic [30:0] RST_GRAVITY    = 31'd64225280;
  localparam logic [30:0] RST_BUOY_RATIO = 31'd65536;
  localparam logic [30:0] RST_TRANS_DEPTH = 31'd6553600;
  localparam logic [30:0] RST_DRAG       = 31'd0;
  localparam logic [30:0] RST_GAIN       = 31'd0;
  localparam logic [30:0] RST_TARGET     = 31'd0;
  localparam logic [30:0] RST_LIMIT      = 31'h7FFFFFFF;
  localparam logic [31:0] RST_WATER      = 32'd0;

  localparam logic [2:0] REG_GRAVITY     = 3'd0;
  localparam logic [2:0] REG_BUOY_RATIO  = 3'd1;
  localparam logic [2:0] REG_TRANS_DEPTH = 3'd2;
  localparam logic [2:0] REG_DRAG        = 3'd3;
  localparam logic [2:0] REG_GAIN        = 3'd4;
  localparam logic [2:0] REG_TARGET      = 3'd5;
  localparam logic [2:0] REG_LIMIT       = 3'd6;
  localparam logic [2:0] REG_WATER       = 3'd7;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] body_height;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic [15:0]        time_step;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_vel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
    logic signed [31:0] depth;
    logic               above_surface;
  } out_item_t;

  typedef struct packed {
    logic [30:0] gravity;
    logic [30:0] buoyancy_ratio;
    logic [30:0] transition_depth;
    logic [30:0] drag_coeff;
    logic [30:0] thrust_gain;
    logic [30:0] target_speed;
    logic [30:0] speed_limit;
    logic [31:0] water_level;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CAPTURE,
    CMD_MUL_DRAG,
    CMD_ACC_DRAG,
    CMD_MUL_RG,
    CMD_SAVE_RG,
    CMD_DIV_INIT_B,
    CMD_DIV_STEP,
    CMD_SET_F,
    CMD_MUL_BLO,
    CMD_SAVE_LO,
    CMD_MUL_BHI,
    CMD_ACC_BHI,
    CMD_MUL_DOT,
    CMD_ACC_DOT,
    CMD_ERR,
    CMD_MUL_ERR,
    CMD_SET_M,
    CMD_MUL_THR,
    CMD_ACC_THR,
    CMD_MUL_DTLO,
    CMD_MUL_DTHI,
    CMD_UPD_V,
    CMD_MUL_SQ,
    CMD_ACC_SQ,
    CMD_MUL_LIM,
    CMD_SQ_INIT,
    CMD_SQ_STEP,
    CMD_MUL_VL,
    CMD_DIV_INIT_L,
    CMD_SET_V,
    CMD_PUBLISH
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [1:0] ax;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic above;
    logic gain_nz;
    logic err_pos;
    logic limit_hit;
  } dp_stat_t;

  function automatic logic [15:0] mag16(input logic [15:0] a);
    return a[15] ? (~a + 16'd1) : a;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  // add a magnitude with a sign, two's complement
  function automatic logic [63:0] signed_add(input logic [63:0] base,
                                             input logic [63:0] m,
                                             input logic neg);
    return neg ? (base - m) : (base + m);
  endfunction

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    if (!v[63] && (v[62:31] != 32'd0)) begin
      r = 32'h7FFFFFFF;
    end else if (v[63] && (v[62:31] != 32'hFFFFFFFF)) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/uvvs_regs.sv
// ----------------------------------------------------------------------------
// uvvs_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module uvvs_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output uvvs_pkg::cfg_t cfg
);

  uvvs_pkg::cfg_t cfg_r;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity          <= uvvs_pkg::RST_GRAVITY;
      cfg_r.buoyancy_ratio   <= uvvs_pkg::RST_BUOY_RATIO;
      cfg_r.transition_depth <= uvvs_pkg::RST_TRANS_DEPTH;
      cfg_r.drag_coeff       <= uvvs_pkg::RST_DRAG;
      cfg_r.thrust_gain      <= uvvs_pkg::RST_GAIN;
      cfg_r.target_speed     <= uvvs_pkg::RST_TARGET;
      cfg_r.speed_limit      <= uvvs_pkg::RST_LIMIT;
      cfg_r.water_level      <= uvvs_pkg::RST_WATER;
    end else if (wr_en) begin
      case (paddr[4:2])
        uvvs_pkg::REG_GRAVITY:     cfg_r.gravity          <= pwdata[30:0];
        uvvs_pkg::REG_BUOY_RATIO:  cfg_r.buoyancy_ratio   <= pwdata[30:0];
        uvvs_pkg::REG_TRANS_DEPTH: cfg_r.transition_depth <= pwdata[30:0];
        uvvs_pkg::REG_DRAG:        cfg_r.drag_coeff       <= pwdata[30:0];
        uvvs_pkg::REG_GAIN:        cfg_r.thrust_gain      <= pwdata[30:0];
        uvvs_pkg::REG_TARGET:      cfg_r.target_speed     <= pwdata[30:0];
        uvvs_pkg::REG_LIMIT:       cfg_r.speed_limit      <= pwdata[30:0];
        uvvs_pkg::REG_WATER:       cfg_r.water_level      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      uvvs_pkg::REG_GRAVITY:     prdata = {1'b0, cfg_r.gravity};
      uvvs_pkg::REG_BUOY_RATIO:  prdata = {1'b0, cfg_r.buoyancy_ratio};
      uvvs_pkg::REG_TRANS_DEPTH: prdata = {1'b0, cfg_r.transition_depth};
      uvvs_pkg::REG_DRAG:        prdata = {1'b0, cfg_r.drag_coeff};
      uvvs_pkg::REG_GAIN:        prdata = {1'b0, cfg_r.thrust_gain};
      uvvs_pkg::REG_TARGET:      prdata = {1'b0, cfg_r.target_speed};
      uvvs_pkg::REG_LIMIT:       prdata = {1'b0, cfg_r.speed_limit};
      uvvs_pkg::REG_WATER:       prdata = cfg_r.water_level;
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/uvvs_dp.sv
// ----------------------------------------------------------------------------
// uvvs_dp
// Datapath: velocity state, one shared 32x32 multiplier, a radix-2 divider,
// a bit-pair square root unit and the result register.
// ----------------------------------------------------------------------------
module uvvs_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  uvvs_pkg::dp_cmd_t    cmd,
  input  uvvs_pkg::in_item_t   in_data,
  input  uvvs_pkg::cfg_t       cfg,
  output uvvs_pkg::dp_stat_t   stat,
  output uvvs_pkg::out_item_t  out_data
);

  logic [31:0] v_r [3];
  logic [63:0] acc_r [3];
  logic [15:0] fwd_r [3];
  logic [15:0] dt_r;
  logic [31:0] depth_r;
  logic        above_r;
  logic        load_r;
  logic [63:0] prod_r;
  logic [63:0] tmp_r;
  logic [45:0] rg_r;
  logic [16:0] f_r;
  logic [63:0] dot_r;
  logic [63:0] err_r;
  logic [30:0] m_r;
  logic [63:0] sumsq_r;
  logic [31:0] rem_r;
  logic [63:0] quo_r;
  logic [31:0] den_r;
  logic [63:0] sqx_r;
  logic [63:0] sqr_r;
  logic [63:0] sqb_r;
  uvvs_pkg::out_item_t out_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [31:0] v_sel;
  logic [15:0] fwd_sel;
  logic [63:0] acc_sel;
  logic [63:0] acc_mag;
  logic [32:0] diff;
  logic [32:0] rem_sh;
  logic        rem_ge;
  logic [64:0] sq_t;
  logic        sq_ge;
  logic [63:0] wide_sum;
  logic [63:0] v_new;
  logic [63:0] s_mag;
  logic [31:0] q_lo;

  assign v_sel   = v_r[cmd.ax];
  assign fwd_sel = fwd_r[cmd.ax];
  assign acc_sel = acc_r[cmd.ax];
  assign acc_mag = uvvs_pkg::mag64(acc_sel);
  assign diff    = {cfg.water_level[31], cfg.water_level}
                 - {in_data.body_height[31], in_data.body_height};
  assign rem_sh  = {rem_r, quo_r[63]};
  assign rem_ge  = rem_sh >= {1'b0, den_r};
  assign sq_t    = {1'b0, sqr_r} + {1'b0, sqb_r};
  assign sq_ge   = {1'b0, sqx_r} >= sq_t;
  // hi partial shifted up plus lo partial
  assign wide_sum = {prod_r[31:0], 32'd0} + tmp_r;
  assign v_new   = {{32{v_sel[31]}}, v_sel}
                 + (acc_sel[63] ? (~{16'd0, wide_sum[63:16]} + 64'd1)
                                : {16'd0, wide_sum[63:16]});
  assign s_mag   = uvvs_pkg::mag64(dot_r) >> uvvs_pkg::FWD_BITS;
  assign q_lo    = quo_r[31:0];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.op)
      uvvs_pkg::CMD_MUL_DRAG: begin
        mul_a = uvvs_pkg::mag32(v_sel);
        mul_b = {1'b0, cfg.drag_coeff};
      end
      uvvs_pkg::CMD_MUL_RG: begin
        mul_a = {1'b0, cfg.buoyancy_ratio};
        mul_b = {1'b0, cfg.gravity};
      end
      uvvs_pkg::CMD_MUL_BLO: begin
        mul_a = rg_r[31:0];
        mul_b = {15'd0, f_r};
      end
      uvvs_pkg::CMD_MUL_BHI: begin
        mul_a = {18'd0, rg_r[45:32]};
        mul_b = {15'd0, f_r};
      end
      uvvs_pkg::CMD_MUL_DOT: begin
        mul_a = uvvs_pkg::mag32(v_sel);
        mul_b = {16'd0, uvvs_pkg::mag16(fwd_sel)};
      end
      uvvs_pkg::CMD_MUL_ERR: begin
        mul_a = {16'd0, err_r[15:0]};
        mul_b = {1'b0, cfg.thrust_gain};
      end
      uvvs_pkg::CMD_MUL_THR: begin
        mul_a = {16'd0, uvvs_pkg::mag16(fwd_sel)};
        mul_b = {1'b0, m_r};
      end
      uvvs_pkg::CMD_MUL_DTLO: begin
        mul_a = acc_mag[31:0];
        mul_b = {16'd0, dt_r};
      end
      uvvs_pkg::CMD_MUL_DTHI: begin
        mul_a = acc_mag[63:32];
        mul_b = {16'd0, dt_r};
      end
      uvvs_pkg::CMD_MUL_SQ: begin
        mul_a = uvvs_pkg::mag32(v_sel);
        mul_b = uvvs_pkg::mag32(v_sel);
      end
      uvvs_pkg::CMD_MUL_LIM: begin
        mul_a = {1'b0, cfg.speed_limit};
        mul_b = {1'b0, cfg.speed_limit};
      end
      uvvs_pkg::CMD_MUL_VL: begin
        mul_a = uvvs_pkg::mag32(v_sel);
        mul_b = {1'b0, cfg.speed_limit};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // velocity state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 32'd0;
      v_r[1] <= 32'd0;
      v_r[2] <= 32'd0;
    end else begin
      case (cmd.op)
        uvvs_pkg::CMD_CAPTURE: begin
          if (in_data.operation == uvvs_pkg::OP_LOAD) begin
            v_r[0] <= in_data.load_vel_x;
            v_r[1] <= in_data.load_vel_y;
            v_r[2] <= in_data.load_vel_z;
          end
        end
        uvvs_pkg::CMD_UPD_V: v_r[cmd.ax] <= uvvs_pkg::sat32(v_new);
        uvvs_pkg::CMD_SET_V: v_r[cmd.ax] <= v_sel[31] ? (~q_lo + 32'd1) : q_lo;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      uvvs_pkg::CMD_CAPTURE: begin
        load_r   <= in_data.operation;
        fwd_r[0] <= in_data.fwd_x;
        fwd_r[1] <= in_data.fwd_y;
        fwd_r[2] <= in_data.fwd_z;
        dt_r     <= in_data.time_step;
        acc_r[0] <= 64'd0;
        acc_r[1] <= 64'd0;
        acc_r[2] <= ~{33'd0, cfg.gravity} + 64'd1;
        dot_r    <= 64'd0;
        sumsq_r  <= 64'd0;
        if (in_data.operation == uvvs_pkg::OP_LOAD) begin
          depth_r <= 32'd0;
          above_r <= 1'b0;
        end else begin
          depth_r <= uvvs_pkg::sat32({{31{diff[32]}}, diff});
          above_r <= diff[32];
        end
      end
      uvvs_pkg::CMD_ACC_DRAG:
        acc_r[cmd.ax] <= uvvs_pkg::signed_add(acc_sel, {16'd0, prod_r[63:16]}, !v_sel[31]);
      uvvs_pkg::CMD_SAVE_RG: rg_r <= prod_r[61:16];
      uvvs_pkg::CMD_DIV_INIT_B: begin
        rem_r <= 32'd0;
        quo_r <= {17'd0, depth_r[30:0], 16'd0};
        den_r <= (cfg.transition_depth < 31'h10000) ? 32'h10000
                                                    : {1'b0, cfg.transition_depth};
      end
      uvvs_pkg::CMD_DIV_STEP: begin
        rem_r <= rem_ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
        quo_r <= {quo_r[62:0], rem_ge};
      end
      uvvs_pkg::CMD_SET_F:
        f_r <= (quo_r[63:16] != 48'd0) ? 17'h10000 : {1'b0, quo_r[15:0]};
      uvvs_pkg::CMD_SAVE_LO: tmp_r <= prod_r;
      uvvs_pkg::CMD_ACC_BHI:
        acc_r[2] <= acc_r[2] + {16'd0, wide_sum[63:16]};
      uvvs_pkg::CMD_ACC_DOT:
        dot_r <= uvvs_pkg::signed_add(dot_r, prod_r, v_sel[31] ^ fwd_sel[15]);
      uvvs_pkg::CMD_ERR:
        err_r <= uvvs_pkg::signed_add({33'd0, cfg.target_speed}, s_mag, !dot_r[63]);
      uvvs_pkg::CMD_SET_M:
        m_r <= (err_r[62:16] != 47'd0) ? cfg.thrust_gain : prod_r[46:16];
      uvvs_pkg::CMD_ACC_THR:
        acc_r[cmd.ax] <= uvvs_pkg::signed_add(acc_sel, {14'd0, prod_r[63:14]}, fwd_sel[15]);
      uvvs_pkg::CMD_ACC_SQ: sumsq_r <= sumsq_r + prod_r;
      uvvs_pkg::CMD_SQ_INIT: begin
        sqx_r <= sumsq_r;
        sqr_r <= 64'd0;
        sqb_r <= 64'h4000000000000000;
      end
      uvvs_pkg::CMD_SQ_STEP: begin
        if (sq_ge) begin
          sqx_r <= sqx_r - sq_t[63:0];
          sqr_r <= (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_r <= sqr_r >> 1;
        end
        sqb_r <= sqb_r >> 2;
      end
      uvvs_pkg::CMD_DIV_INIT_L: begin
        rem_r <= 32'd0;
        quo_r <= prod_r;
        den_r <= (sqr_r[31:0] == 32'd0) ? 32'd1 : sqr_r[31:0];
      end
      uvvs_pkg::CMD_PUBLISH: begin
        out_r.out_vel_x     <= v_r[0];
        out_r.out_vel_y     <= v_r[1];
        out_r.out_vel_z     <= v_r[2];
        out_r.depth         <= depth_r;
        out_r.above_surface <= above_r;
      end
      default: ;
    endcase
    // product register follows every multiply command
    case (cmd.op)
      uvvs_pkg::CMD_MUL_DRAG, uvvs_pkg::CMD_MUL_RG, uvvs_pkg::CMD_MUL_BLO,
      uvvs_pkg::CMD_MUL_BHI, uvvs_pkg::CMD_MUL_DOT, uvvs_pkg::CMD_MUL_ERR,
      uvvs_pkg::CMD_MUL_THR, uvvs_pkg::CMD_MUL_DTLO, uvvs_pkg::CMD_MUL_DTHI,
      uvvs_pkg::CMD_MUL_SQ, uvvs_pkg::CMD_MUL_LIM, uvvs_pkg::CMD_MUL_VL:
        prod_r <= mul_p;
      default: ;
    endcase
  end

  always_comb begin
    stat.is_load   = load_r;
    stat.above     = above_r;
    stat.gain_nz   = cfg.thrust_gain != 31'd0;
    stat.err_pos   = !err_r[63] && (err_r != 64'd0);
    stat.limit_hit = sumsq_r > prod_r;
  end

  assign out_data = out_r;

endmodule

// File: rtl/uvvs_ctrl.sv
// ----------------------------------------------------------------------------
// uvvs_ctrl
// Sequencer: walks the datapath through one load or tick item and owns the
// channel handshakes.
// ----------------------------------------------------------------------------
module uvvs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  uvvs_pkg::dp_stat_t  stat,
  output uvvs_pkg::dp_cmd_t   cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DISP  = 16'h0002,
    S_DRAG  = 16'h0004,
    S_BUOY  = 16'h0008,
    S_DIV   = 16'h0010,
    S_BLEND = 16'h0020,
    S_DOT   = 16'h0040,
    S_ERR   = 16'h0080,
    S_THRA  = 16'h0100,
    S_INT   = 16'h0200,
    S_SQ    = 16'h0400,
    S_CMP   = 16'h0800,
    S_SQRT  = 16'h1000,
    S_LIMV  = 16'h2000,
    S_LIMW  = 16'h4000,
    S_FIN   = 16'h8000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic        lim_r, lim_nxt;
  logic        out_valid_r, out_valid_nxt;
  state_t      after_buoy;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign after_buoy = stat.gain_nz ? S_DOT : S_INT;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    ax_nxt    = ax_r;
    lim_nxt   = lim_r;
    cmd.op    = uvvs_pkg::CMD_NOP;
    cmd.ax    = 2'd0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = 6'd0;
        if (in_valid) begin
          cmd.op    = uvvs_pkg::CMD_CAPTURE;
          lim_nxt   = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cnt_nxt   = 6'd0;
        state_nxt = stat.is_load ? S_FIN : S_DRAG;
      end
      S_DRAG: begin
        cmd.ax = cnt_r[2:1];
        cmd.op = cnt_r[0] ? uvvs_pkg::CMD_ACC_DRAG : uvvs_pkg::CMD_MUL_DRAG;
        if (cnt_r == 6'd5) begin
          cnt_nxt   = 6'd0;
          state_nxt = stat.above ? after_buoy : S_BUOY;
        end
      end
      S_BUOY: begin
        case (cnt_r[1:0])
          2'd0:    cmd.op = uvvs_pkg::CMD_MUL_RG;
          2'd1:    cmd.op = uvvs_pkg::CMD_SAVE_RG;
          default: begin
            cmd.op    = uvvs_pkg::CMD_DIV_INIT_B;
            cnt_nxt   = 6'd0;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        cmd.op = uvvs_pkg::CMD_DIV_STEP;
        if (cnt_r == 6'd63) begin
          cnt_nxt   = 6'd0;
          state_nxt = lim_r ? S_LIMW : S_BLEND;
        end
      end
      S_BLEND: begin
        case (cnt_r[2:0])
          3'd0:    cmd.op = uvvs_pkg::CMD_SET_F;
          3'd1:    cmd.op = uvvs_pkg::CMD_MUL_BLO;
          3'd2:    cmd.op = uvvs_pkg::CMD_SAVE_LO;
          3'd3:    cmd.op = uvvs_pkg::CMD_MUL_BHI;
          default: begin
            cmd.op    = uvvs_pkg::CMD_ACC_BHI;
            cnt_nxt   = 6'd0;
            state_nxt = after_buoy;
          end
        endcase
      end
      S_DOT: begin
        cmd.ax = cnt_r[2:1];
        cmd.op = cnt_r[0] ? uvvs_pkg::CMD_ACC_DOT : uvvs_pkg::CMD_MUL_DOT;
        if (cnt_r == 6'd5) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        case (cnt_r[1:0])
          2'd0: cmd.op = uvvs_pkg::CMD_ERR;
          2'd1: begin
            if (stat.err_pos) begin
              cmd.op = uvvs_pkg::CMD_MUL_ERR;
            end else begin
              cnt_nxt   = 6'd0;
              state_nxt = S_INT;
            end
          end
          default: begin
            cmd.op    = uvvs_pkg::CMD_SET_M;
            cnt_nxt   = 6'd0;
            state_nxt = S_THRA;
          end
        endcase
      end
      S_THRA: begin
        cmd.ax = cnt_r[2:1];
        cmd.op = cnt_r[0] ? uvvs_pkg::CMD_ACC_THR : uvvs_pkg::CMD_MUL_THR;
        if (cnt_r == 6'd5) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        cmd.ax = cnt_r[3:2];
        case (cnt_r[1:0])
          2'd0:    cmd.op = uvvs_pkg::CMD_MUL_DTLO;
          2'd1:    cmd.op = uvvs_pkg::CMD_SAVE_LO;
          2'd2:    cmd.op = uvvs_pkg::CMD_MUL_DTHI;
          default: cmd.op = uvvs_pkg::CMD_UPD_V;
        endcase
        if (cnt_r == 6'd11) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.ax = cnt_r[2:1];
        cmd.op = cnt_r[0] ? uvvs_pkg::CMD_ACC_SQ : uvvs_pkg::CMD_MUL_SQ;
        if (cnt_r == 6'd5) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (cnt_r[0] == 1'b0) begin
          cmd.op = uvvs_pkg::CMD_MUL_LIM;
        end else begin
          cnt_nxt = 6'd0;
          if (stat.limit_hit) begin
            cmd.op    = uvvs_pkg::CMD_SQ_INIT;
            lim_nxt   = 1'b1;
            ax_nxt    = 2'd0;
            state_nxt = S_SQRT;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SQRT: begin
        cmd.op = uvvs_pkg::CMD_SQ_STEP;
        if (cnt_r == 6'd31) begin
          cnt_nxt   = 6'd0;
          state_nxt = S_LIMV;
        end
      end
      S_LIMV: begin
        cmd.ax = ax_r;
        if (cnt_r[0] == 1'b0) begin
          cmd.op = uvvs_pkg::CMD_MUL_VL;
        end else begin
          cmd.op    = uvvs_pkg::CMD_DIV_INIT_L;
          cnt_nxt   = 6'd0;
          state_nxt = S_DIV;
        end
      end
      S_LIMW: begin
        cmd.ax  = ax_r;
        cmd.op  = uvvs_pkg::CMD_SET_V;
        cnt_nxt = 6'd0;
        if (ax_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_LIMV;
        end
      end
      S_FIN: begin
        cnt_nxt = 6'd0;
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.op        = uvvs_pkg::CMD_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        cnt_nxt   = 6'd0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 6'd0;
      ax_r        <= 2'd0;
      lim_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ax_r        <= ax_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`include "underwater_vehicle_velocity_step_assert.svh"

  `UVVS_ASSERT_NEXT(a_publish_sets_valid, (state_r == S_FIN) && !out_valid_r, out_valid_r, "publish lost")
  `UVVS_ASSERT_NEXT(a_accept_to_disp, (state_r == S_IDLE) && in_valid, state_r == S_DISP, "capture skipped")
  `UVVS_ASSERT_SAME(a_sqrt_count, state_r == S_SQRT, cnt_r < 6'd32, "sqrt overrun")
  `UVVS_ASSERT_SAME(a_limw_axis, state_r == S_LIMW, lim_r && (ax_r != 2'd3), "bad limit axis")

endmodule

// File: rtl/underwater_vehicle_velocity_step.sv
// ----------------------------------------------------------------------------
// underwater_vehicle_velocity_step
// Fixed-point velocity update of an underwater vehicle.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_stall/in_data, results leave on
// out_valid/out_stall/out_data; a transfer happens when valid is high and
// stall is low. Every item gives exactly one result.
// A load item goes straight to publish after capture. A tick item applies drag,
// then the buoyancy blend (64-step divider) unless the body is above the
// surface, then thrust when the gain is nonzero and the speed error is
// positive, then integration. When the speed limit clamps, a 32-step square
// root and three per-axis divisions follow. One 32x32 multiplier is shared
// by every product. One item is worked at a time; the next transfer is taken
// in the cycle after the result is published, even while that result is
// still stalled. A finished item then waits for the result register.
// Reset clears the velocity to zero, loads the register defaults and clears
// the result valid flag. The user must write registers through the APB-style
// port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module underwater_vehicle_velocity_step (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  uvvs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output uvvs_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  uvvs_pkg::cfg_t     cfg;
  uvvs_pkg::dp_cmd_t  cmd;
  uvvs_pkg::dp_stat_t stat;

  uvvs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uvvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  uvvs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg      (cfg),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
